// File: hw/rtl/fcsn_pkg.sv
// Shared types, register codes and the circle table for the FAST score and suppression block.
`timescale 1ns / 1ps

package fcsn_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [7:0]  THRESHOLD_RST = 8'd20;
  localparam logic [10:0] WIDTH_RST     = 11'd640;
  localparam logic [10:0] HEIGHT_RST    = 11'd480;
  localparam int          MIN_SIZE      = 8;

  // Item kinds
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_PADDING = 1'b1;

  // Radius-3 Bresenham circle, 16 points
  localparam int CIRCLE_DX [16] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
  localparam int CIRCLE_DY [16] = '{3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3};

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel_value;
    logic       is_corner;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  corner_x;
    logic [9:0]  corner_y;
    logic [11:0] corner_score;
  } out_item_t;

  typedef logic [7:0] term_arr_t [16];

  // Balanced adder tree over the 16 circle terms
  function automatic logic [11:0] sum16(input term_arr_t v);
    logic [8:0]  l1 [8];
    logic [9:0]  l2 [4];
    logic [10:0] l3 [2];
    for (int i = 0; i < 8; i++) begin
      l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    return {1'b0, l3[0]} + {1'b0, l3[1]};
  endfunction

endpackage

// File: hw/rtl/fast_corner_score_nonmax.sv
// FAST corner score with 3x3 non-maximum suppression over a raster pixel stream.
// A kept corner is carried from the transaction that decides it through stages 1 to 5 to out_valid.
// Throughput: one transaction per cycle; the whole pipeline stalls only while a result waits.
// The pixel window is fed by six line buffers, the score window by two, one read port each.
// Reset (rst, synchronous): registers return to threshold 20, 640 x 480, position 0, no
// result pending; line buffer contents stay undefined and are never used before written.
`timescale 1ns / 1ps

module fast_corner_score_nonmax #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fcsn_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fcsn_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcsn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcsn_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 5);

  // Configuration registers
  logic [7:0]  threshold;
  logic [10:0] image_width;
  logic [10:0] image_height;
  logic [CW:0]   w_eff;
  logic [RW-1:0] h_eff;

  // Raster position and history of the last four steps
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] hcol [4];
  logic [RW-1:0] hrow [4];

  logic en;
  logic step;
  logic in_frame;
  logic frame_end;
  logic [CW:0] col_inc;
  logic cfg_wr;
  logic restart;

  // Stage 1: accepted step, line buffer reads in flight
  logic          p1_valid;
  logic [7:0]    p1_pix;
  logic          p1_mark;
  logic [CW-1:0] p1_col;
  logic [CW-1:0] p1_scol;
  logic [RW-1:0] p1_srow;
  logic [CW-1:0] p1_qcol;
  logic [RW-1:0] p1_qrow;

  // Stage 2: pixel window holds the scoring neighborhood
  logic          p2_valid;
  logic [CW-1:0] p2_scol;
  logic [RW-1:0] p2_srow;
  logic [CW-1:0] p2_qcol;
  logic [RW-1:0] p2_qrow;

  // Stage 3: circle terms
  logic                p3_valid;
  logic                p3_mark;
  fcsn_pkg::term_arr_t p3_pos;
  fcsn_pkg::term_arr_t p3_neg;
  logic [CW-1:0]       p3_scol;
  logic [CW-1:0]       p3_qcol;
  logic [RW-1:0]       p3_qrow;

  // Stage 4: score entry, score line buffer reads in flight
  logic          p4_valid;
  logic [12:0]   p4_entry;
  logic [CW-1:0] p4_scol;
  logic [CW-1:0] p4_qcol;
  logic [RW-1:0] p4_qrow;

  // Stage 5: score window holds the suppression neighborhood
  logic          p5_valid;
  logic [CW-1:0] p5_qcol;
  logic [RW-1:0] p5_qrow;

  logic [8:0]  pwin [7][7];
  logic [12:0] swin [3][3];
  logic [8:0]  lb_rd [6];
  logic [8:0]  lb_wr [6];
  logic [12:0] slb_rd [2];
  logic [12:0] slb_wr [2];

  fcsn_pkg::term_arr_t pos_term;
  fcsn_pkg::term_arr_t neg_term;
  logic [11:0] pos_sum;
  logic [11:0] neg_sum;
  logic        keep;

  // Handshake: one output register, the pipeline moves whenever it can drain
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr && (cfg_index == fcsn_pkg::REG_IMAGE_WIDTH ||
                                cfg_index == fcsn_pkg::REG_IMAGE_HEIGHT);

  // Clamped frame size
  always_comb begin
    if (image_width < 11'(fcsn_pkg::MIN_SIZE)) begin
      w_eff = (CW+1)'(fcsn_pkg::MIN_SIZE);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(image_width);
    end
    if (image_height < 11'(fcsn_pkg::MIN_SIZE)) begin
      h_eff = RW'(fcsn_pkg::MIN_SIZE);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(image_height);
    end
  end

  // Step decode: padding inside the frame is dropped
  assign in_frame  = row < h_eff;
  assign step      = in_valid && en && !(in_frame && in_data.kind == fcsn_pkg::KIND_PADDING);
  assign frame_end = (row == h_eff + RW'(4)) && (col == CW'(3));
  assign col_inc   = {1'b0, col} + (CW+1)'(1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= fcsn_pkg::THRESHOLD_RST;
      image_width  <= fcsn_pkg::WIDTH_RST;
      image_height <= fcsn_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        fcsn_pkg::REG_THRESHOLD:    threshold    <= cfg_data[7:0];
        fcsn_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        fcsn_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Position counters and step history
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
      for (int i = 0; i < 4; i++) begin
        hcol[i] <= '0;
        hrow[i] <= '0;
      end
    end else if (step) begin
      hcol[0] <= col;
      hrow[0] <= row;
      for (int i = 1; i < 4; i++) begin
        hcol[i] <= hcol[i-1];
        hrow[i] <= hrow[i-1];
      end
      if (frame_end) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= w_eff) begin
        col <= '0;
        row <= row + RW'(1);
      end else begin
        col <= col_inc[CW-1:0];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      p4_valid  <= 1'b0;
      p5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p1_valid  <= step;
      p2_valid  <= p1_valid;
      p3_valid  <= p2_valid;
      p4_valid  <= p3_valid;
      p5_valid  <= p4_valid;
      out_valid <= p5_valid && keep;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      p1_pix   <= in_data.pixel_value;
      p1_mark  <= in_data.is_corner;
      p1_col   <= col;
      p1_scol  <= hcol[2];
      p1_srow  <= hrow[2];
      p1_qcol  <= hcol[3];
      p1_qrow  <= hrow[3];
      p2_scol  <= p1_scol;
      p2_srow  <= p1_srow;
      p2_qcol  <= p1_qcol;
      p2_qrow  <= p1_qrow;
      p3_mark  <= pwin[3][3][8];
      p3_pos   <= pos_term;
      p3_neg   <= neg_term;
      p3_scol  <= p2_scol;
      p3_qcol  <= p2_qcol;
      p3_qrow  <= p2_qrow;
      p4_entry <= p3_mark ? {1'b1, ((pos_sum > neg_sum) ? pos_sum : neg_sum)} : 13'd0;
      p4_scol  <= p3_scol;
      p4_qcol  <= p3_qcol;
      p4_qrow  <= p3_qrow;
      p5_qcol  <= p4_qcol;
      p5_qrow  <= p4_qrow;
      out_data.corner_x     <= 10'(p5_qcol);
      out_data.corner_y     <= 10'(p5_qrow - RW'(4));
      out_data.corner_score <= swin[1][1][11:0];
    end
  end

  // Pixel line buffers: each row moves one buffer down as its column is revisited
  assign lb_wr[0] = {p1_mark, p1_pix};
  for (genvar k = 1; k < 6; k++) begin : g_lb_chain
    assign lb_wr[k] = lb_rd[k-1];
  end

  for (genvar k = 0; k < 6; k++) begin : g_lb
    logic [8:0] mem [MAX_WIDTH];
    logic [8:0] rd_q;
    always_ff @(posedge clk) begin
      if (en) begin
        rd_q <= mem[col];
        if (p1_valid) begin
          mem[p1_col] <= lb_wr[k];
        end
      end
    end
    assign lb_rd[k] = rd_q;
  end

  // 7x7 pixel window, column 0 newest, row 0 current
  always_ff @(posedge clk) begin
    if (en && p1_valid) begin
      for (int k = 0; k < 7; k++) begin
        for (int j = 6; j > 0; j--) begin
          pwin[k][j] <= pwin[k][j-1];
        end
      end
      pwin[0][0] <= {p1_mark, p1_pix};
      for (int k = 1; k < 7; k++) begin
        pwin[k][0] <= lb_rd[k-1];
      end
    end
  end

  // Circle terms, points outside the image contribute nothing
  always_comb begin
    logic [CW+1:0] cx;
    logic [RW:0]   ry;
    logic          inside_img;
    logic [7:0]    c;
    logic [7:0]    p;
    logic [9:0]    d_hi;
    logic [9:0]    d_lo;
    c = pwin[3][3][7:0];
    for (int i = 0; i < 16; i++) begin
      cx = (CW+2)'(p2_scol) + (CW+2)'(fcsn_pkg::CIRCLE_DX[i] + 3);
      ry = (RW+1)'(p2_srow) + (RW+1)'(fcsn_pkg::CIRCLE_DY[i] + 3);
      inside_img = (cx >= (CW+2)'(3)) && (cx < (CW+2)'(w_eff) + (CW+2)'(3)) &&
                   (ry >= (RW+1)'(6)) && (ry < (RW+1)'(h_eff) + (RW+1)'(6));
      p = pwin[3 - fcsn_pkg::CIRCLE_DY[i]][3 - fcsn_pkg::CIRCLE_DX[i]][7:0];
      d_hi = {2'b0, p} - {2'b0, c} - {2'b0, threshold};
      d_lo = {2'b0, c} - {2'b0, threshold} - {2'b0, p};
      pos_term[i] = (inside_img && !d_hi[9] && d_hi != 10'd0) ? d_hi[7:0] : 8'd0;
      neg_term[i] = (inside_img && !d_lo[9] && d_lo != 10'd0) ? d_lo[7:0] : 8'd0;
    end
  end

  assign pos_sum = fcsn_pkg::sum16(p3_pos);
  assign neg_sum = fcsn_pkg::sum16(p3_neg);

  // Score line buffers
  assign slb_wr[0] = p4_entry;
  assign slb_wr[1] = slb_rd[0];

  for (genvar k = 0; k < 2; k++) begin : g_slb
    logic [12:0] mem [MAX_WIDTH];
    logic [12:0] rd_q;
    always_ff @(posedge clk) begin
      if (en) begin
        rd_q <= mem[p3_scol];
        if (p4_valid) begin
          mem[p4_scol] <= slb_wr[k];
        end
      end
    end
    assign slb_rd[k] = rd_q;
  end

  // 3x3 score window
  always_ff @(posedge clk) begin
    if (en && p4_valid) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 2; j > 0; j--) begin
          swin[k][j] <= swin[k][j-1];
        end
      end
      swin[0][0] <= p4_entry;
      swin[1][0] <= slb_rd[0];
      swin[2][0] <= slb_rd[1];
    end
  end

  // Suppression: keep a marked center with no strictly higher in-image neighbor
  always_comb begin
    logic [CW+1:0] cx;
    logic [RW:0]   ry;
    keep = swin[1][1][12] && (p5_qrow >= RW'(4)) && (p5_qrow < h_eff + RW'(4));
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        cx = (CW+2)'(p5_qcol) + (CW+2)'(dx + 1);
        ry = (RW+1)'(p5_qrow) + (RW+1)'(dy + 1);
        if (!(dx == 0 && dy == 0) &&
            (cx >= (CW+2)'(1)) && (cx < (CW+2)'(w_eff) + (CW+2)'(1)) &&
            (ry >= (RW+1)'(5)) && (ry < (RW+1)'(h_eff) + (RW+1)'(5)) &&
            (swin[1-dy][1-dx][11:0] > swin[1][1][11:0])) begin
          keep = 1'b0;
        end
      end
    end
  end

endmodule
